### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: default geometry, mode codes
// and the character and attribute values used by the screen store.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // default screen geometry
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;
   localparam int POS_W_DEF   = $clog2(COLUMNS_DEF * ROWS_DEF);

   // field widths of the request and response items
   localparam int MODE_W = 3;
   localparam int BYTE_W = 8;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SETPOS = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

   // character and attribute values
   localparam logic [BYTE_W-1:0] CHAR_BLANK   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CRETURN = 8'h0D;
   localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h07;

endpackage

`default_nettype wire

### rtl/tcw_req_if.sv
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel of the text console writer: valid/ready with one command.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::MODE_W-1:0]  mode;
   logic [tcw_pkg::BYTE_W-1:0]  char_code;
   logic [tcw_pkg::BYTE_W-1:0]  col;
   logic [tcw_pkg::BYTE_W-1:0]  row;

   modport source (output valid, output mode, output char_code, output col,
                   output row, input ready);
   modport sink   (input valid, input mode, input char_code, input col,
                   input row, output ready);
endinterface

`default_nettype wire

### rtl/tcw_rsp_if.sv
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel of the text console writer: cursor position and cell data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_rsp_if #(
   parameter int POS_W = tcw_pkg::POS_W_DEF
);
   logic                        valid;
   logic                        ready;
   logic [POS_W-1:0]            cursor_position;
   logic [tcw_pkg::BYTE_W-1:0]  cell_char;
   logic [tcw_pkg::BYTE_W-1:0]  cell_attribute;

   modport source (output valid, output cursor_position, output cell_char,
                   output cell_attribute, input ready);
   modport sink   (input valid, input cursor_position, input cell_char,
                   input cell_attribute, output ready);
endinterface

`default_nettype wire

### rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with enable,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console engine: a screen of character and attribute bytes held in
// two RAMs, a cursor, and a sweep sequencer for clear, scroll and init.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command (mode, char_code, col, row); a transfer takes
//   place when valid and ready are both high. rsp_chan returns one item per
//   command: the cursor position after the command and, for a read, the
//   character and attribute of the cell (zero otherwise). csr_we/csr_wdata
//   set the attribute byte used for writes, blanks and clears.
//   Put char, backspace, set position and read go from IDLE to DONE, where
//   the response is loaded behind the registered RAM read, once the output
//   register is free; one that scrolls passes through the scroll states first.
//   Clear sweeps every cell at one per cycle.
//   A scroll copies each character up with a read state and a write state,
//   then blanks the bottom row.
//   One command is in flight at a time; the response sits in an output
//   register, so the next request is taken while the receiver stalls.
//   After reset the screen is filled with spaces and attribute 0x07; while
//   this runs req_chan.ready is low, and csr writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   tcw_req_if.sink                          req_chan,
   tcw_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_we,
   input  wire logic [tcw_pkg::BYTE_W-1:0]  csr_wdata
);

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = ROWS * (2 ** COL_W);
   localparam int POS_W  = $clog2(ROWS * COLUMNS);
   localparam int BW     = tcw_pkg::BYTE_W;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [BW-1:0]    COL_LIM  = BW'(COLUMNS);
   localparam logic [BW-1:0]    ROW_LIM  = BW'(ROWS);

   // state codes
   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CLEAR  = 3'd2;
   localparam logic [2:0] ST_SCR_RD = 3'd3;
   localparam logic [2:0] ST_SCR_WR = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [COL_W-1:0] cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0] cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0] sw_col_ff, sw_col_in;
   logic [ROW_W-1:0] sw_row_ff, sw_row_in;
   logic [BW-1:0]    fill_attr_ff, fill_attr_in;
   logic [BW-1:0]    csr_attr_ff, csr_attr_in;
   logic             rd_hit_ff, rd_hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [BW-1:0]    rsp_char_ff, rsp_char_in;
   logic [BW-1:0]    rsp_attr_ff, rsp_attr_in;

   // memory port controls
   logic              char_we, attr_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [BW-1:0]     char_wdata, attr_wdata;
   logic [BW-1:0]     char_rdata, attr_rdata;

   logic             req_ready, accept, rsp_load;
   logic             sw_last_col, sw_last;
   logic             nl_scroll;
   logic [ROW_W-1:0] nl_row;
   logic             col_hit, row_hit, is_newline;
   logic [POS_W-1:0] cursor_pos;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid & req_ready;
   assign req_chan.ready = req_ready;

   assign sw_last_col = (sw_col_ff == COL_LAST);
   assign sw_last     = sw_last_col && (sw_row_ff == ROW_LAST);

   // new line from the current cursor
   assign nl_scroll = (cursor_row_ff == ROW_LAST);
   assign nl_row    = nl_scroll ? ROW_LAST : cursor_row_ff + ROW_W'(1);

   assign col_hit    = (req_chan.col < COL_LIM);
   assign row_hit    = (req_chan.row < ROW_LIM);
   assign is_newline = (req_chan.char_code == tcw_pkg::CHAR_NEWLINE) ||
                       (req_chan.char_code == tcw_pkg::CHAR_CRETURN);

   assign cursor_pos = POS_W'(cursor_row_ff) * POS_W'(COLUMNS) + POS_W'(cursor_col_ff);

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      sw_col_in     = sw_col_ff;
      sw_row_in     = sw_row_ff;
      fill_attr_in  = fill_attr_ff;
      rd_hit_in     = rd_hit_ff;
      char_we       = 1'b0;
      attr_we       = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = {sw_row_ff, sw_col_ff};
      mem_raddr     = {sw_row_ff + ROW_W'(1), sw_col_ff};
      char_wdata    = tcw_pkg::CHAR_BLANK;
      attr_wdata    = fill_attr_ff;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            char_we = 1'b1;
            attr_we = 1'b1;
            if (sw_last) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end else if (sw_last_col) begin
               sw_col_in = '0;
               sw_row_in = sw_row_ff + ROW_W'(1);
            end else begin
               sw_col_in = sw_col_ff + COL_W'(1);
            end
         end

         ST_IDLE: begin
            if (accept) begin
               sw_col_in = '0;
               sw_row_in = '0;
               rd_hit_in = 1'b0;
               state_in  = ST_DONE;
               attr_wdata = csr_attr_ff;
               case (req_chan.mode)
                  tcw_pkg::MODE_PUT: begin
                     if (!is_newline) begin
                        char_we    = 1'b1;
                        attr_we    = 1'b1;
                        mem_waddr  = {cursor_row_ff, cursor_col_ff};
                        char_wdata = req_chan.char_code;
                     end
                     if (is_newline || cursor_col_ff == COL_LAST) begin
                        cursor_col_in = '0;
                        cursor_row_in = nl_row;
                        if (nl_scroll) begin
                           state_in = ST_SCR_RD;
                        end
                     end else begin
                        cursor_col_in = cursor_col_ff + COL_W'(1);
                     end
                  end

                  tcw_pkg::MODE_BACK: begin
                     if (cursor_col_ff == '0) begin
                        if (cursor_row_ff != '0) begin
                           cursor_col_in = COL_LAST;
                           cursor_row_in = cursor_row_ff - ROW_W'(1);
                        end
                     end else begin
                        cursor_col_in = cursor_col_ff - COL_W'(1);
                     end
                     char_we   = 1'b1;
                     attr_we   = 1'b1;
                     mem_waddr = {cursor_row_in, cursor_col_in};
                  end

                  tcw_pkg::MODE_CLEAR: begin
                     fill_attr_in = csr_attr_ff;
                     state_in     = ST_CLEAR;
                  end

                  tcw_pkg::MODE_SETPOS: begin
                     if (col_hit) begin
                        if (row_hit) begin
                           cursor_col_in = COL_W'(req_chan.col);
                           cursor_row_in = ROW_W'(req_chan.row);
                        end else begin
                           // scroll resets the column
                           cursor_col_in = '0;
                           cursor_row_in = ROW_LAST;
                           state_in      = ST_SCR_RD;
                        end
                     end else begin
                        cursor_col_in = '0;
                        cursor_row_in = nl_row;
                        if (nl_scroll) begin
                           state_in = ST_SCR_RD;
                        end
                     end
                  end

                  tcw_pkg::MODE_READ: begin
                     rd_hit_in = col_hit && row_hit;
                     mem_re    = col_hit && row_hit;
                     mem_raddr = {ROW_W'(req_chan.row), COL_W'(req_chan.col)};
                  end

                  default: begin
                  end
               endcase
            end
         end

         ST_SCR_RD: begin
            if (sw_row_ff == ROW_LAST) begin
               // bottom row gets blanks, attributes untouched
               char_we = 1'b1;
               if (sw_last) begin
                  state_in = ST_DONE;
               end else begin
                  sw_col_in = sw_col_ff + COL_W'(1);
               end
            end else begin
               mem_re   = 1'b1;
               state_in = ST_SCR_WR;
            end
         end

         ST_SCR_WR: begin
            char_we    = 1'b1;
            char_wdata = char_rdata;
            state_in   = ST_SCR_RD;
            if (sw_last_col) begin
               sw_col_in = '0;
               sw_row_in = sw_row_ff + ROW_W'(1);
            end else begin
               sw_col_in = sw_col_ff + COL_W'(1);
            end
         end

         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = cursor_pos;
         rsp_char_in  = rd_hit_ff ? char_rdata : '0;
         rsp_attr_in  = rd_hit_ff ? attr_rdata : '0;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign csr_attr_in = csr_we ? csr_wdata : csr_attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         sw_col_ff     <= '0;
         sw_row_ff     <= '0;
         fill_attr_ff  <= tcw_pkg::ATTR_RESET;
         csr_attr_ff   <= tcw_pkg::ATTR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         sw_col_ff     <= sw_col_in;
         sw_row_ff     <= sw_row_in;
         fill_attr_ff  <= fill_attr_in;
         csr_attr_ff   <= csr_attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_hit_ff   <= rd_hit_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.cursor_position = rsp_pos_ff;
   assign rsp_chan.cell_char       = rsp_char_ff;
   assign rsp_chan.cell_attribute  = rsp_attr_ff;

   tcw_ram #(
      .WIDTH (BW),
      .DEPTH (DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (char_we),
      .wr_addr (mem_waddr),
      .wr_data (char_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (char_rdata)
   );

   tcw_ram #(
      .WIDTH (BW),
      .DEPTH (DEPTH)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (mem_waddr),
      .wr_data (attr_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (attr_rdata)
   );

endmodule

`default_nettype wire

### rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to text_console_writer_core.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF,
   localparam int POS_W  = $clog2(ROWS * COLUMNS)
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [POS_W-1:0]            rsp_pos,
   input wire logic [tcw_pkg::BYTE_W-1:0]  rsp_char,
   input wire logic [tcw_pkg::BYTE_W-1:0]  rsp_attr
);

   localparam logic [POS_W:0] CELLS = (POS_W + 1)'(ROWS * COLUMNS);

   // a stalled response keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pos) && $stable(rsp_char) && $stable(rsp_attr))
      else $error("response payload changed while stalled");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one command at a time: ready drops after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in flight");

   // cursor stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_pos} < CELLS)
      else $error("cursor position off the screen");

endmodule

bind text_console_writer_core tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_pos   (rsp_chan.cursor_position),
   .rsp_char  (rsp_chan.cell_char),
   .rsp_attr  (rsp_chan.cell_attribute)
);

`default_nettype wire
